/* sv/ufrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufrs_pkg: shared types and constants of the union-find engine
// Field widths, rank limits, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ufrs_pkg;

    // Widths of the word fields on the request and response channels.
    localparam int ELEM_W = 10;
    localparam int SIZE_W = 11;

    // Largest element count that the 10-bit element index can reach.
    localparam int MAX_ELEMS = 1 << ELEM_W;

    // Default element count of the store.
    localparam int NUM_ELEMS_DEF = 1024;

    // Rank of a tree: reset value and saturation limit.
    localparam int          RANK_W    = 4;
    localparam logic [3:0]  RANK_INIT = 4'd1;
    localparam logic [3:0]  RANK_MAX  = 4'd15;

    // Operation codes.
    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_MERGE = 1'b1;

    // Which element of a merge the sequencer is resolving.
    localparam logic SIDE_A = 1'b0;
    localparam logic SIDE_B = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_LINK_CHILD,
        ST_LINK_ROOT,
        ST_FIN
    } ufrs_state_t;

endpackage
`default_nettype wire

/* sv/ufrs_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufrs_req_if: request channel of the union-find engine
// Carries one find or merge word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufrs_req_if;

    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [ufrs_pkg::ELEM_W-1:0] elem_a;
    logic [ufrs_pkg::ELEM_W-1:0] elem_b;

    modport source (output valid, output operation, output elem_a, output elem_b,
                    input ready);
    modport sink   (input valid, input operation, input elem_a, input elem_b,
                    output ready);

endinterface
`default_nettype wire

/* sv/ufrs_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufrs_rsp_if: response channel of the union-find engine
// Carries one result word (root, set size, merged flag) with valid/ready.
// ----------------------------------------------------------------------------
interface ufrs_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [ufrs_pkg::ELEM_W-1:0] root;
    logic [ufrs_pkg::SIZE_W-1:0] set_size;
    logic                        merged;

    modport source (output valid, output root, output set_size, output merged,
                    input ready);
    modport sink   (input valid, input root, input set_size, input merged,
                    output ready);

endinterface
`default_nettype wire

/* sv/ufrs_node_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufrs_node_mem: node store of the union-find engine
// One write port and one read port with registered read data. Each word packs
// the parent index, the tree rank and the set size of one element.
// ----------------------------------------------------------------------------
module ufrs_node_mem #(
    parameter int DEPTH  = ufrs_pkg::NUM_ELEMS_DEF,
    parameter int AW     = $clog2(DEPTH),
    parameter int WORD_W = AW + ufrs_pkg::RANK_W + $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] node_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= node_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* sv/union_find_rank_size_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_rank_size_core: disjoint-set engine with union by rank
// Finds the root and size of an element's set, or merges two sets, with full
// path compression on every find.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the node store once, one element per cycle, so
// it takes its first request only once the whole store (at most 1024 elements)
// is cleared after reset is released. All work goes through a single node
// memory with one read and one write port. A find walks up the chain from its
// element to the root, then makes a compression pass that repoints each visited
// node at the root. A merge does this for each of its two elements and, when
// two distinct sets are joined, then rewrites the losing root and the winning
// root one after the other. An element index at or above NUM_ELEMS is a lone
// singleton and is not walked.
// The result is held in an output register, so the next request is taken while
// a result still waits for the consumer.
// ----------------------------------------------------------------------------
module union_find_rank_size_core #(
    parameter int NUM_ELEMS = ufrs_pkg::NUM_ELEMS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ufrs_req_if.sink    req,
    ufrs_rsp_if.source  rsp
);

    // Only the indices that the element field can reach are stored.
    localparam int DEPTH  = (NUM_ELEMS < ufrs_pkg::MAX_ELEMS) ? NUM_ELEMS
                                                              : ufrs_pkg::MAX_ELEMS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int RW     = ufrs_pkg::RANK_W;
    localparam int WORD_W = AW + RW + CW;
    localparam int ELEM_W = ufrs_pkg::ELEM_W;
    localparam int SIZE_W = ufrs_pkg::SIZE_W;

    // Sequencer state.
    ufrs_pkg::ufrs_state_t state_reg, state_next;

    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     a_idx_reg, a_idx_next;
    logic [AW-1:0]     b_idx_reg, b_idx_next;
    logic              b_ok_reg, b_ok_next;
    logic              op_reg, op_next;
    logic              side_reg, side_next;
    logic [AW-1:0]     ra_reg, ra_next;
    logic [RW-1:0]     rank_a_reg, rank_a_next;
    logic [CW-1:0]     cnt_a_reg, cnt_a_next;
    logic [AW-1:0]     rb_reg, rb_next;
    logic [RW-1:0]     rank_b_reg, rank_b_next;
    logic [CW-1:0]     cnt_b_reg, cnt_b_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [ELEM_W-1:0] res_root_reg, res_root_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic              res_merged_reg, res_merged_next;
    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] out_root_reg, out_root_next;
    logic [SIZE_W-1:0] out_size_reg, out_size_next;
    logic              out_merged_reg, out_merged_next;

    // Node store port signals.
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic [AW-1:0]     mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;

    // Fields of the word read back from the store.
    logic [AW-1:0]     rd_parent;
    logic [RW-1:0]     rd_rank;
    logic [CW-1:0]     rd_cnt;

    // Link decision for a merge of two distinct roots.
    logic              a_wins;
    logic [AW-1:0]     win_root;
    logic [AW-1:0]     child_root;
    logic [RW-1:0]     child_rank;
    logic [CW-1:0]     child_cnt;
    logic [RW-1:0]     win_rank;
    logic [CW-1:0]     sum_cnt;
    logic [AW-1:0]     cur_root;
    logic              a_ok;
    logic              b_ok;

    ufrs_node_mem #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .WORD_W (WORD_W)
    ) u_node_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign rd_parent = mem_rd_data[WORD_W-1 -: AW];
    assign rd_rank   = mem_rd_data[CW+RW-1 -: RW];
    assign rd_cnt    = mem_rd_data[CW-1:0];

    // Range checks of the incoming element indices.
    assign a_ok = ({1'b0, req.elem_a} < SIZE_W'(DEPTH));
    assign b_ok = ({1'b0, req.elem_b} < SIZE_W'(DEPTH));

    // The root being resolved right now.
    assign cur_root = (side_reg == ufrs_pkg::SIDE_B) ? rb_reg : ra_reg;

    // The lower rank goes under the higher; a tie hangs b's root under a's.
    assign a_wins     = !(rank_a_reg < rank_b_reg);
    assign win_root   = a_wins ? ra_reg : rb_reg;
    assign child_root = a_wins ? rb_reg : ra_reg;
    assign child_rank = a_wins ? rank_b_reg : rank_a_reg;
    assign child_cnt  = a_wins ? cnt_b_reg : cnt_a_reg;
    assign sum_cnt    = cnt_a_reg + cnt_b_reg;

    always_comb
    begin
        if (!a_wins)
        begin
            win_rank = rank_b_reg;
        end
        else if (rank_a_reg == rank_b_reg && rank_a_reg != ufrs_pkg::RANK_MAX)
        begin
            win_rank = rank_a_reg + RW'(1);
        end
        else
        begin
            win_rank = rank_a_reg;
        end
    end

    // State register and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ufrs_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        a_idx_reg      <= a_idx_next;
        b_idx_reg      <= b_idx_next;
        b_ok_reg       <= b_ok_next;
        op_reg         <= op_next;
        side_reg       <= side_next;
        ra_reg         <= ra_next;
        rank_a_reg     <= rank_a_next;
        cnt_a_reg      <= cnt_a_next;
        rb_reg         <= rb_next;
        rank_b_reg     <= rank_b_next;
        cnt_b_reg      <= cnt_b_next;
        res_root_reg   <= res_root_next;
        res_size_reg   <= res_size_next;
        res_merged_reg <= res_merged_next;
        out_root_reg   <= out_root_next;
        out_size_reg   <= out_size_next;
        out_merged_reg <= out_merged_next;
    end

    // Sequencer: next state, store accesses and result.
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        a_idx_next      = a_idx_reg;
        b_idx_next      = b_idx_reg;
        b_ok_next       = b_ok_reg;
        op_next         = op_reg;
        side_next       = side_reg;
        ra_next         = ra_reg;
        rank_a_next     = rank_a_reg;
        cnt_a_next      = cnt_a_reg;
        rb_next         = rb_reg;
        rank_b_next     = rank_b_reg;
        cnt_b_next      = cnt_b_reg;
        clr_next        = clr_reg;
        res_root_next   = res_root_reg;
        res_size_next   = res_size_reg;
        res_merged_next = res_merged_reg;
        out_valid_next  = out_valid_reg;
        out_root_next   = out_root_reg;
        out_size_next   = out_size_reg;
        out_merged_next = out_merged_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cur_reg;
        mem_wr_data     = mem_rd_data;
        mem_rd_addr     = cur_reg;

        // The consumer took the pending result word.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ufrs_pkg::ST_CLEAR:
            begin
                // Every element becomes its own singleton set.
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = {clr_reg, ufrs_pkg::RANK_INIT, CW'(1)};
                clr_next    = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ufrs_pkg::ST_IDLE;
                end
            end

            ufrs_pkg::ST_IDLE:
            begin
                mem_rd_addr = req.elem_a[AW-1:0];
                if (req.valid)
                begin
                    cur_next   = req.elem_a[AW-1:0];
                    a_idx_next = req.elem_a[AW-1:0];
                    b_idx_next = req.elem_b[AW-1:0];
                    b_ok_next  = b_ok;
                    op_next    = req.operation;
                    side_next  = ufrs_pkg::SIDE_A;
                    if (a_ok)
                    begin
                        state_next = ufrs_pkg::ST_WALK;
                    end
                    else
                    begin
                        // An element outside the store is a lone singleton.
                        res_root_next   = req.elem_a;
                        res_size_next   = SIZE_W'(1);
                        res_merged_next = 1'b0;
                        state_next      = ufrs_pkg::ST_FIN;
                    end
                end
            end

            ufrs_pkg::ST_WALK:
            begin
                if (rd_parent == cur_reg)
                begin
                    // Root reached: keep its rank and size, then compress.
                    if (side_reg == ufrs_pkg::SIDE_B)
                    begin
                        rb_next     = cur_reg;
                        rank_b_next = rd_rank;
                        cnt_b_next  = rd_cnt;
                        cur_next    = b_idx_reg;
                        mem_rd_addr = b_idx_reg;
                    end
                    else
                    begin
                        ra_next     = cur_reg;
                        rank_a_next = rd_rank;
                        cnt_a_next  = rd_cnt;
                        cur_next    = a_idx_reg;
                        mem_rd_addr = a_idx_reg;
                    end
                    state_next = ufrs_pkg::ST_COMP;
                end
                else
                begin
                    cur_next    = rd_parent;
                    mem_rd_addr = rd_parent;
                end
            end

            ufrs_pkg::ST_COMP:
            begin
                if (cur_reg != cur_root)
                begin
                    // Point this node straight at the root and move up.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cur_reg;
                    mem_wr_data = {cur_root, rd_rank, rd_cnt};
                    cur_next    = rd_parent;
                    mem_rd_addr = rd_parent;
                end
                else if (side_reg == ufrs_pkg::SIDE_A)
                begin
                    if (op_reg == ufrs_pkg::OP_MERGE && b_ok_reg)
                    begin
                        side_next   = ufrs_pkg::SIDE_B;
                        cur_next    = b_idx_reg;
                        mem_rd_addr = b_idx_reg;
                        state_next  = ufrs_pkg::ST_WALK;
                    end
                    else
                    begin
                        res_root_next   = ELEM_W'(ra_reg);
                        res_size_next   = SIZE_W'(cnt_a_reg);
                        res_merged_next = 1'b0;
                        state_next      = ufrs_pkg::ST_FIN;
                    end
                end
                else if (ra_reg == rb_reg)
                begin
                    // Both elements already share a set.
                    res_root_next   = ELEM_W'(ra_reg);
                    res_size_next   = SIZE_W'(cnt_a_reg);
                    res_merged_next = 1'b0;
                    state_next      = ufrs_pkg::ST_FIN;
                end
                else
                begin
                    state_next = ufrs_pkg::ST_LINK_CHILD;
                end
            end

            ufrs_pkg::ST_LINK_CHILD:
            begin
                // Hang the losing root under the winner.
                mem_wr_en   = 1'b1;
                mem_wr_addr = child_root;
                mem_wr_data = {win_root, child_rank, child_cnt};
                state_next  = ufrs_pkg::ST_LINK_ROOT;
            end

            ufrs_pkg::ST_LINK_ROOT:
            begin
                // The winner takes the summed size and its new rank.
                mem_wr_en       = 1'b1;
                mem_wr_addr     = win_root;
                mem_wr_data     = {win_root, win_rank, sum_cnt};
                res_root_next   = ELEM_W'(win_root);
                res_size_next   = SIZE_W'(sum_cnt);
                res_merged_next = 1'b1;
                state_next      = ufrs_pkg::ST_FIN;
            end

            ufrs_pkg::ST_FIN:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_root_next   = res_root_reg;
                    out_size_next   = res_size_reg;
                    out_merged_next = res_merged_reg;
                    state_next      = ufrs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ufrs_pkg::ST_IDLE;
            end
        endcase
    end

    assign req.ready    = (state_reg == ufrs_pkg::ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.root     = out_root_reg;
    assign rsp.set_size = out_size_reg;
    assign rsp.merged   = out_merged_reg;

    // A compression write never lands on the node being read in that cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufrs_pkg::ST_COMP && mem_wr_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("compression write collides with the chain read");

    // Linking is only reached for two distinct roots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufrs_pkg::ST_LINK_CHILD) |-> (ra_reg != rb_reg))
        else $error("link started for a single root");

    // An accepted word always starts work, never leaves the engine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ufrs_pkg::ST_IDLE))
        else $error("accepted word was dropped");

    // A joined set holds at least two elements and never more than the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.merged) |-> (rsp.set_size >= SIZE_W'(2)))
        else $error("merged set smaller than two");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.set_size != '0 && rsp.set_size <= SIZE_W'(DEPTH)))
        else $error("set size out of range");

endmodule
`default_nettype wire

/* tb/ufrs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufrs_checker: result predictor and scoreboard for the union-find engine
// Watches both channels, keeps its own copy of the disjoint-set forest, works
// out the result of every accepted request word and compares each accepted
// response word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ufrs_checker
    import ufrs_pkg::*;
#(
    parameter int NUM_ELEMS = NUM_ELEMS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ufrs_req_if  req,
    ufrs_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [ELEM_W-1:0] root;
        logic [SIZE_W-1:0] set_size;
        logic              merged;
    } dsu_result_t;

    // Shadow forest: parent links, tree heights and member counts at roots.
    logic [ELEM_W-1:0] link_up [NUM_ELEMS];
    logic [RANK_W-1:0] height  [NUM_ELEMS];
    logic [SIZE_W-1:0] members [NUM_ELEMS];

    dsu_result_t predicted_results[$];

    // Walks up to the root of x, then points every node on the way at it.
    function automatic int resolve_root(input int x);
        int r;
        int cur;
        int nxt;
        int steps;
        r = x;
        steps = 0;
        while (int'(link_up[r]) != r && steps < NUM_ELEMS)
        begin
            r = int'(link_up[r]);
            steps++;
        end
        cur = x;
        steps = 0;
        while (cur != r && steps < NUM_ELEMS)
        begin
            nxt = int'(link_up[cur]);
            link_up[cur] = ELEM_W'(r);
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    // Applies one find or merge to the shadow forest and returns its result.
    function automatic dsu_result_t apply_word(input logic op,
                                               input logic [ELEM_W-1:0] a,
                                               input logic [ELEM_W-1:0] b);
        dsu_result_t res;
        int ra;
        int rb;
        int top;
        res.merged = 1'b0;
        if (int'(a) >= NUM_ELEMS)
        begin
            // An element outside the store is a lone singleton.
            res.root = a;
            res.set_size = SIZE_W'(1);
        end
        else
        begin
            ra = resolve_root(int'(a));
            top = ra;
            if (op == OP_MERGE && int'(b) < NUM_ELEMS)
            begin
                rb = resolve_root(int'(b));
                if (rb != ra)
                begin
                    res.merged = 1'b1;
                    if (height[ra] < height[rb])
                    begin
                        link_up[ra] = ELEM_W'(rb);
                        members[rb] = members[rb] + members[ra];
                        top = rb;
                    end
                    else
                    begin
                        // On a tie the root of elem_b goes under that of elem_a.
                        link_up[rb] = ELEM_W'(ra);
                        if (height[rb] == height[ra] && height[ra] < RANK_MAX)
                            height[ra] = height[ra] + 1'b1;
                        members[ra] = members[ra] + members[rb];
                        top = ra;
                    end
                end
            end
            res.root = ELEM_W'(top);
            res.set_size = members[top];
        end
        return res;
    endfunction

    // Responses are checked before the request of the same edge is taken, so a
    // result that appears in the cycle of its own request is caught.
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        dsu_result_t want;
        dsu_result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                link_up[i] = ELEM_W'(i);
                height[i]  = RANK_INIT;
                members[i] = SIZE_W'(1);
            end
            predicted_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result word expected none, actual root=%0d size=%0d merged=%0d",
                             $time, rsp.root, rsp.set_size, rsp.merged);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (rsp.root !== want.root)
                    begin
                        $display("%0t: root expected %0d, actual %0d",
                                 $time, want.root, rsp.root);
                        fail_count++;
                    end
                    if (rsp.set_size !== want.set_size)
                    begin
                        $display("%0t: set_size expected %0d, actual %0d",
                                 $time, want.set_size, rsp.set_size);
                        fail_count++;
                    end
                    if (rsp.merged !== want.merged)
                    begin
                        $display("%0t: merged expected %0d, actual %0d",
                                 $time, want.merged, rsp.merged);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = apply_word(req.operation, req.elem_a, req.elem_b);
                predicted_results = {predicted_results, fresh};
            end
            pending = predicted_results.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level of the union-find engine verification
// Drives find and merge words with random gaps, stalls the response side at
// random, and leaves prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module testbench;
    import ufrs_pkg::*;

    localparam int NUM_ELEMS = NUM_ELEMS_DEF;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending;

    // Words left in a stretch without idling, per side.
    int send_quiet;
    int take_quiet;

    ufrs_req_if req_ch ();
    ufrs_rsp_if rsp_ch ();

    union_find_rank_size_core #(
        .NUM_ELEMS (NUM_ELEMS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ufrs_checker #(
        .NUM_ELEMS (NUM_ELEMS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Wait before the next word: mostly a random draw, with runs of none.
    function automatic int draw_wait(ref int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 18);
    endfunction

    // Presents one request word after a random gap and holds it until taken.
    // Called and left at a falling edge.
    task automatic send_word(input logic op, input logic [ELEM_W-1:0] a,
                             input logic [ELEM_W-1:0] b);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.elem_a    <= a;
        req_ch.elem_b    <= b;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Response side: a random stall before each word, then ready until taken.
    initial
    begin : response_side
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(take_quiet);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic              op;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        int                pool;
        int                lo;
        int                merge_pct;

        clk              = 1'b0;
        rst_n            = 1'b0;
        send_quiet       = 0;
        take_quiet       = 0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_FIND;
        req_ch.elem_a    = '0;
        req_ch.elem_b    = '0;
        rsp_ch.ready     = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Singletons at both ends of the index range; elem_b is ignored on a find.
        send_word(OP_FIND,  10'd0,    10'd1023);
        send_word(OP_FIND,  10'd1023, 10'd0);
        send_word(OP_FIND,  10'h2AA,  10'h155);
        // Equal ranks: the second root goes under the first, whose rank grows.
        send_word(OP_MERGE, 10'd0,    10'd1);
        // Both already in one set, in either order.
        send_word(OP_MERGE, 10'd1,    10'd0);
        send_word(OP_MERGE, 10'd0,    10'd1);
        // Merging an element with itself.
        send_word(OP_MERGE, 10'd5,    10'd5);
        send_word(OP_MERGE, 10'd2,    10'd3);
        // Tie between two rank-two trees, reached through non-root elements.
        send_word(OP_MERGE, 10'd3,    10'd1);
        send_word(OP_MERGE, 10'd1023, 10'd1022);
        // Lower-rank root of elem_a is hung under the root of elem_b.
        send_word(OP_MERGE, 10'd4,    10'd1023);
        send_word(OP_MERGE, 10'd1022, 10'd0);
        // Finds through chains that path compression then flattens.
        send_word(OP_FIND,  10'd4,    10'd0);
        send_word(OP_FIND,  10'd1,    10'd0);
        send_word(OP_FIND,  10'd4,    10'd1023);
        send_word(OP_MERGE, 10'h155,  10'h2AA);
        send_word(OP_MERGE, 10'h2AA,  10'd1023);
        send_word(OP_FIND,  10'h155,  10'h3FF);
        send_word(OP_MERGE, 10'd6,    10'd7);
        send_word(OP_MERGE, 10'd1023, 10'd7);
        send_word(OP_FIND,  10'd6,    10'd5);

        // Random phases over windows of varied size, so small windows build
        // deep trees and frequent same-set merges.
        repeat (10)
        begin
            case ($urandom_range(0, 3))
                0:       pool = 4;
                1:       pool = 16;
                2:       pool = 64;
                default: pool = NUM_ELEMS;
            endcase
            lo = $urandom_range(0, NUM_ELEMS - pool);
            merge_pct = $urandom_range(50, 90);
            repeat (100)
            begin
                a  = ELEM_W'(lo + $urandom_range(0, pool - 1));
                b  = ELEM_W'(lo + $urandom_range(0, pool - 1));
                op = ($urandom_range(0, 99) < merge_pct) ? OP_MERGE : OP_FIND;
                if (op == OP_FIND && $urandom_range(0, 1) == 1)
                    b = ELEM_W'($urandom);
                send_word(op, a, b);
            end
        end

        req_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (64) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
